@@ hw/rtl/rmema_pkg.sv @@
// ----------------------------------------------------------------------------
// rmema_pkg: constants for the running mean and EMA unit
// Fixed weight format of the exponential average.
// ----------------------------------------------------------------------------
package rmema_pkg;

	// weight is an unsigned fraction in 1/256 steps
	localparam int unsigned WEIGHT_BITS = 9;
	localparam int unsigned WEIGHT_FRAC = 8;
	localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE   = 9'd256;
	localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = 9'd128;

	typedef logic [WEIGHT_BITS-1:0] weight_t;

endpackage : rmema_pkg

@@ hw/rtl/running_mean_and_ema_unit.sv @@
// ----------------------------------------------------------------------------
// running_mean_and_ema_unit: cumulative mean and exponential moving average
// Per signed sample, returns sum/count (truncated toward zero), the EMA and
// the sample count, with a flag once the count has saturated.
// ----------------------------------------------------------------------------
// One sample in, one result out. After a sample transfer the sequencer
// first updates the EMA, sum and count, then a radix-2 restoring divider
// forms the mean one quotient bit per cycle, and then the output register
// is loaded. The sample itself is captured on the transfer edge. in_ready
// is high only while the sequencer is idle, and the sequencer goes idle on
// the load, so a new sample is taken only once the result of the last one
// has been loaded into the output register; until then the unit holds off
// further samples, whether or not the receiver keeps up. A finished
// result may sit in the output register while the next sample is already
// taken; if it is still there when the next result is ready, the sequencer
// waits in its last state until the receiver takes it. The EMA is the
// first sample after reset, then floor((sample*w + ema*(256-w))/256), with w
// the ema_weight register (9 bits, reset 128, values above 256 act as 256).
// Once the count reaches 2^COUNT_BITS-1 the sum and count freeze, the mean
// stays put, the EMA keeps tracking and count_full reads 1. Write the weight
// only while no sample is in flight.
module running_mean_and_ema_unit #(
	parameter int unsigned SAMPLE_BITS = 16,
	parameter int unsigned COUNT_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration: ema_weight
	input  logic                          cfg_wr_en,
	input  rmema_pkg::weight_t            cfg_wr_data,
	// sample channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] mean,
	output logic signed [SAMPLE_BITS-1:0] ema,
	output logic        [COUNT_BITS-1:0]  sample_count,
	output logic                          count_full
);

	// sum never overflows at this width
	localparam int unsigned DW     = SAMPLE_BITS + COUNT_BITS;
	localparam int unsigned ITER_W = $clog2(DW);
	// sample minus ema, and its product with a 10-bit signed weight
	localparam int unsigned DIFF_W = SAMPLE_BITS + 1;
	localparam int unsigned PROD_W = DIFF_W + rmema_pkg::WEIGHT_BITS + 1;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EMA,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t                        state_q;
	rmema_pkg::weight_t            weight_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic signed [SAMPLE_BITS-1:0] ema_q;
	logic signed [DW-1:0]          sum_q;
	logic        [COUNT_BITS-1:0]  counted_q;
	// divider: dividend/quotient shift register, partial remainder, step count
	logic        [DW-1:0]          quo_q;
	logic        [COUNT_BITS-1:0]  rem_q;
	logic        [ITER_W-1:0]      iter_q;
	logic                          neg_q;

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] mean_q;
	logic signed [SAMPLE_BITS-1:0] ema_out_q;
	logic        [COUNT_BITS-1:0]  count_out_q;
	logic                          full_out_q;

	// EMA datapath: ema + floor(w*(sample-ema)/256)
	rmema_pkg::weight_t            w_sat;
	logic signed [DIFF_W-1:0]      diff;
	logic signed [PROD_W-1:0]      prod;
	logic signed [PROD_W-1:0]      ema_wide;
	logic signed [SAMPLE_BITS-1:0] ema_next;

	// sum and count update
	logic                          count_open;
	logic signed [DW-1:0]          sum_next;
	logic        [COUNT_BITS-1:0]  count_next;
	logic        [DW-1:0]          sum_mag;

	// one restoring divide step
	logic        [COUNT_BITS:0]    rem_shift;
	logic                          step_ge;
	logic        [COUNT_BITS:0]    rem_sub;

	logic                          in_xfer;
	logic                          out_load;
	logic        [SAMPLE_BITS-1:0] quo_low;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	// output register frees up when empty or its result is being taken
	assign out_load = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		w_sat    = weight_q[rmema_pkg::WEIGHT_BITS-1] ? rmema_pkg::WEIGHT_ONE : weight_q;
		diff     = DIFF_W'(sample_q) - DIFF_W'(ema_q);
		prod     = PROD_W'(diff) * $signed({1'b0, w_sat});
		ema_wide = PROD_W'(ema_q) + (prod >>> rmema_pkg::WEIGHT_FRAC);
		// first sample after reset seeds the average
		if (counted_q == '0) begin
			ema_next = sample_q;
		end else begin
			ema_next = ema_wide[SAMPLE_BITS-1:0];
		end
	end

	always_comb begin
		count_open = (counted_q != COUNT_MAX);
		if (count_open) begin
			sum_next   = sum_q + DW'(sample_q);
			count_next = counted_q + COUNT_BITS'(1);
		end else begin
			sum_next   = sum_q;
			count_next = counted_q;
		end
		// |sum| < 2^(DW-1), so the magnitude fits unsigned in DW bits
		sum_mag = sum_next[DW-1] ? DW'(-sum_next) : DW'(sum_next);
	end

	always_comb begin
		rem_shift = {rem_q, quo_q[DW-1]};
		step_ge   = (rem_shift >= {1'b0, counted_q});
		rem_sub   = rem_shift - {1'b0, counted_q};
		quo_low   = quo_q[SAMPLE_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			weight_q    <= rmema_pkg::WEIGHT_RESET;
			sample_q    <= '0;
			ema_q       <= '0;
			sum_q       <= '0;
			counted_q   <= '0;
			quo_q       <= '0;
			rem_q       <= '0;
			iter_q      <= '0;
			neg_q       <= 1'b0;
			out_valid_q <= 1'b0;
			mean_q      <= '0;
			ema_out_q   <= '0;
			count_out_q <= '0;
			full_out_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				weight_q <= cfg_wr_data;
			end
			// a new load wins over the transfer of the old result
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						sample_q <= sample;
						state_q  <= ST_EMA;
					end
				end
				ST_EMA: begin
					ema_q     <= ema_next;
					sum_q     <= sum_next;
					counted_q <= count_next;
					quo_q     <= sum_mag;
					neg_q     <= sum_next[DW-1];
					rem_q     <= '0;
					iter_q    <= ITER_W'(DW - 1);
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					// remainder stays below the divisor, so it fits COUNT_BITS
					if (step_ge) begin
						rem_q <= rem_sub[COUNT_BITS-1:0];
					end else begin
						rem_q <= rem_shift[COUNT_BITS-1:0];
					end
					quo_q <= {quo_q[DW-2:0], step_ge};
					if (iter_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						iter_q <= iter_q - ITER_W'(1);
					end
				end
				ST_FIN: begin
					if (out_load) begin
						// truncation toward zero: negate the magnitude quotient
						mean_q      <= neg_q ? -quo_low : quo_low;
						ema_out_q   <= ema_q;
						count_out_q <= counted_q;
						full_out_q  <= (counted_q == COUNT_MAX);
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign mean         = mean_q;
	assign ema          = ema_out_q;
	assign sample_count = count_out_q;
	assign count_full   = full_out_q;

`ifndef SYNTHESIS
	a_xfer_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == ST_EMA) && !in_ready)
		else $error("sample transfer did not start the sequencer");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) && (iter_q == '0) |=> (state_q == ST_FIN))
		else $error("divider overran its step count");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < counted_q))
		else $error("partial remainder not below divisor");

	a_count_mono: assert property (@(posedge clk) disable iff (!arst_n)
		counted_q >= $past(counted_q))
		else $error("sample count went backward");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q && (state_q == ST_IDLE))
		else $error("result load lost");
`endif

endmodule : running_mean_and_ema_unit
